[hdl/sobel_edge_threshold_macros.svh]
// Assertion macros for the Sobel edge threshold block.
// Used by files that hold concurrent checks; expects clk and arst_n in scope.
`ifndef SOBEL_EDGE_THRESHOLD_MACROS_SVH
`define SOBEL_EDGE_THRESHOLD_MACROS_SVH

// same-cycle implication, masked during reset
`define SOBEL_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, masked during reset
`define SOBEL_ASSERT_NXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[hdl/sobel_pkg.sv]
// Shared constants and types for the Sobel edge threshold block.
// No dependencies; imported by the interfaces and the top-level module.
`timescale 1ns / 1ps
`default_nettype none

package sobel_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int MIN_SIZE   = 3;

	localparam int PIX_W  = 8;
	localparam int POS_W  = 12;   // row / column counters and result fields
	localparam int SIZE_W = 13;   // image_width / image_height registers
	localparam int THR_W  = 11;
	localparam int CFG_W  = 13;   // widest register
	localparam int CIDX_W = 2;

	localparam int GRAD_W = 11;   // signed gradient, |g| <= 1020
	localparam int SQ_W   = 20;   // g*g <= 1040400
	localparam int MAG_W  = 21;
	localparam int T2_W   = 2 * THR_W;

	// line-store entry: {row r-2, row r-1}
	localparam int LS_W = 2 * PIX_W;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(4000);
	localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(4000);
	localparam logic [THR_W-1:0]  THR_RST    = THR_W'(30);

	typedef enum logic [CIDX_W-1:0] {
		CFG_IMAGE_WIDTH,
		CFG_IMAGE_HEIGHT,
		CFG_EDGE_THRESHOLD
	} cfg_index_t;

endpackage

`default_nettype wire

[hdl/sobel_pix_if.sv]
// Pixel input channel: valid/ready handshake with one grayscale pixel.
// Depends on sobel_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sobel_pix_if import sobel_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;

	modport source(output valid, output pixel, input ready);
	modport sink(input valid, input pixel, output ready);
endinterface

`default_nettype wire

[hdl/sobel_res_if.sv]
// Result output channel: valid/ready handshake with edge flag and position.
// Depends on sobel_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sobel_res_if import sobel_pkg::*;;
	logic             valid;
	logic             ready;
	logic             is_edge;
	logic [POS_W-1:0] row;
	logic [POS_W-1:0] column;
	logic             last_in_frame;

	modport source(output valid, output is_edge, output row, output column,
		output last_in_frame, input ready);
	modport sink(input valid, input is_edge, input row, input column,
		input last_in_frame, output ready);
endinterface

`default_nettype wire

[hdl/sobel_edge_threshold.sv]
// Sobel 3x3 edge detector with threshold: top level. Uses sobel_pkg, sobel_pix_if,
// sobel_res_if, sobel_ram and the assertion macros.
// A result for an accepted pixel goes through stage 1, stage 2, stage 3 and the output register.
// Throughput: one pixel per cycle while the result channel does not stall; set by the line-store RMW.
// Reset (arst_n low): counters and window cleared, registers to 4000/4000/30.
// The line store itself is not cleared; results use only entries written earlier in the frame.
`timescale 1ns / 1ps
`default_nettype none

`include "sobel_edge_threshold_macros.svh"

module sobel_edge_threshold import sobel_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	sobel_pix_if.sink              pixels,
	sobel_res_if.source            results,
	input  wire logic              cfg_wr_en,
	input  wire logic [CIDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_wdata
);

	// ------------------------------------------------------------------
	// Configuration registers, effective sizes, threshold squared
	// ------------------------------------------------------------------
	logic [SIZE_W-1:0] width_q, height_q;
	logic [THR_W-1:0]  thr_q;
	logic [T2_W-1:0]   thr_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			thr_q    <= THR_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:    width_q  <= cfg_wdata[SIZE_W-1:0];
				CFG_IMAGE_HEIGHT:   height_q <= cfg_wdata[SIZE_W-1:0];
				CFG_EDGE_THRESHOLD: thr_q    <= cfg_wdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Squared threshold, registered from thr_q. The user keeps config changes only while idle; unenforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_sq_q <= T2_W'(THR_RST) * T2_W'(THR_RST);
		end else begin
			thr_sq_q <= T2_W'(thr_q) * T2_W'(thr_q);
		end
	end

	// Out-of-range sizes saturate to 3..max
	logic [SIZE_W-1:0] w_eff, h_eff;
	logic [POS_W-1:0]  w_last, h_last;

	always_comb begin
		if (width_q < SIZE_W'(MIN_SIZE)) begin
			w_eff = SIZE_W'(MIN_SIZE);
		end else if (width_q > SIZE_W'(MAX_WIDTH)) begin
			w_eff = SIZE_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q < SIZE_W'(MIN_SIZE)) begin
			h_eff = SIZE_W'(MIN_SIZE);
		end else if (height_q > SIZE_W'(MAX_HEIGHT)) begin
			h_eff = SIZE_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	assign w_last = POS_W'(w_eff - SIZE_W'(1));
	assign h_last = POS_W'(h_eff - SIZE_W'(1));

	// ------------------------------------------------------------------
	// Pipeline control: every stage advances together whenever the output
	// register is free or being drained. The output register is the skid
	// point, so a new pixel is taken in the same cycle a result transfers.
	// ------------------------------------------------------------------
	logic adv;
	logic in_xfer;

	assign adv          = !results.valid || results.ready;
	assign pixels.ready = adv;
	assign in_xfer      = pixels.valid && adv;

	// ------------------------------------------------------------------
	// Raster position of the next pixel
	// ------------------------------------------------------------------
	logic [POS_W-1:0] col_q, row_q;
	logic             col_wrap, row_wrap;

	// ">=" rather than "==" so a counter left past a shrunken size still wraps
	assign col_wrap = ({1'b0, col_q} + SIZE_W'(1)) >= w_eff;
	assign row_wrap = ({1'b0, row_q} + SIZE_W'(1)) >= h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + POS_W'(1);
			end else begin
				col_q <= col_q + POS_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Line store: one RAM, entry = {row r-2, row r-1} at each column.
	// Read at accept, data back in s1; s1 writes {old r-1, new pixel} back.
	// Consecutive pixels never share a column (width >= 3), and the previous
	// access to a column is a full row earlier, so no forwarding is needed.
	// ------------------------------------------------------------------
	logic [LS_W-1:0]  ls_rd_data;
	logic [LS_W-1:0]  ls_wr_data;
	logic             ls_wr_en;

	logic             valid_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [POS_W-1:0] col_s1;
	logic             emit_s1;
	logic             last_s1;
	logic [POS_W-1:0] row_out_s1, col_out_s1;

	assign ls_wr_en   = valid_s1 && adv;
	assign ls_wr_data = {ls_rd_data[PIX_W-1:0], pix_s1};

	sobel_ram #(
		.WIDTH (LS_W),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.wr_en   (ls_wr_en),
		.wr_addr (col_s1),
		.wr_data (ls_wr_data),
		.rd_en   (in_xfer),
		.rd_addr (col_q),
		.rd_data (ls_rd_data)
	);

	// Stage 1: position bookkeeping while the RAM read is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pixels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pix_s1     <= pixels.pixel;
			col_s1     <= col_q;
			emit_s1    <= (row_q >= POS_W'(2)) && (col_q >= POS_W'(2));
			last_s1    <= (row_q == h_last) && (col_q == w_last);
			row_out_s1 <= row_q - POS_W'(1);
			col_out_s1 <= col_q - POS_W'(1);
		end
	end

	// ------------------------------------------------------------------
	// 3x3 window: [0..1] top, [2..3] middle, [4..5] bottom; left then centre.
	// Right column comes straight from the RAM and the incoming pixel.
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] win_q [6];
	logic [PIX_W-1:0] top, mid;

	assign top = ls_rd_data[LS_W-1:PIX_W];
	assign mid = ls_rd_data[PIX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (ls_wr_en) begin
			win_q[0] <= win_q[1];
			win_q[1] <= top;
			win_q[2] <= win_q[3];
			win_q[3] <= mid;
			win_q[4] <= win_q[5];
			win_q[5] <= pix_s1;
		end
	end

	// Kernel sums; each side is at most 4*255 and fits 10 bits
	logic [GRAD_W-2:0]       gx_pos, gx_neg, gy_pos, gy_neg;
	logic signed [GRAD_W-1:0] gx, gy;

	assign gx_pos = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, pix_s1};
	assign gx_neg = {2'b00, win_q[0]} + {1'b0, win_q[2], 1'b0} + {2'b00, win_q[4]};
	assign gy_pos = {2'b00, win_q[4]} + {1'b0, win_q[5], 1'b0} + {2'b00, pix_s1};
	assign gy_neg = {2'b00, win_q[0]} + {1'b0, win_q[1], 1'b0} + {2'b00, top};
	assign gx     = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
	assign gy     = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});

	// ------------------------------------------------------------------
	// Stage 2: gradients. Only interior centres continue past here.
	// ------------------------------------------------------------------
	logic                     valid_s2;
	logic signed [GRAD_W-1:0] gx_s2, gy_s2;
	logic                     last_s2;
	logic [POS_W-1:0]         row_s2, col_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gx_s2   <= gx;
			gy_s2   <= gy;
			last_s2 <= last_s1;
			row_s2  <= row_out_s1;
			col_s2  <= col_out_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: squares
	// ------------------------------------------------------------------
	logic signed [2*GRAD_W-1:0] sqx, sqy;
	logic                       valid_s3;
	logic [SQ_W-1:0]            sqx_s3, sqy_s3;
	logic                       last_s3;
	logic [POS_W-1:0]           row_s3, col_s3;

	assign sqx = gx_s2 * gx_s2;
	assign sqy = gy_s2 * gy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s3  <= sqx[SQ_W-1:0];
			sqy_s3  <= sqy[SQ_W-1:0];
			last_s3 <= last_s2;
			row_s3  <= row_s2;
			col_s3  <= col_s2;
		end
	end

	// ------------------------------------------------------------------
	// Output register: magnitude compare against threshold squared
	// ------------------------------------------------------------------
	logic [MAG_W-1:0] mag2;

	assign mag2 = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.valid <= 1'b0;
		end else if (adv) begin
			results.valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			results.is_edge       <= T2_W'(mag2) > thr_sq_q;
			results.row           <= row_s3;
			results.column        <= col_s3;
			results.last_in_frame <= last_s3;
		end
	end

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`SOBEL_ASSERT_IMP(a_ls_no_same_col, ls_wr_en && in_xfer, col_s1 != col_q, "line store RMW collision")
	`SOBEL_ASSERT_NXT(a_accept_fills_s1, in_xfer, valid_s1, "accepted pixel not in stage 1")
	`SOBEL_ASSERT_IMP(a_result_interior, results.valid, (results.row != '0) && (results.column != '0), "border result emitted")

endmodule

`default_nettype wire

[hdl/sobel_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sobel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// output holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire
